>>> design/assert_macros.svh
// Assertion macros shared by the design files; empty when synthesized.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

>>> design/ptc_pkg.sv
// Types and constants shared by the path to turn command block.
`timescale 1ns / 1ps

package ptc_pkg;

    // Default limit on the number of path points taken in one run.
    localparam int MAX_POINTS_DEFAULT = 20;

    // Headings: north is decreasing row, east is increasing column.
    localparam logic [1:0] HEAD_N = 2'd0;
    localparam logic [1:0] HEAD_E = 2'd1;
    localparam logic [1:0] HEAD_S = 2'd2;
    localparam logic [1:0] HEAD_W = 2'd3;

    // Command codes.
    localparam logic [1:0] CODE_RIGHT = 2'd0;
    localparam logic [1:0] CODE_LEFT  = 2'd1;
    localparam logic [1:0] CODE_END   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_ROW  = 3'd0;
    localparam logic [2:0] CFG_START_COL  = 3'd1;
    localparam logic [2:0] CFG_TARGET_ROW = 3'd2;
    localparam logic [2:0] CFG_TARGET_COL = 3'd3;
    localparam logic [2:0] CFG_HEADING    = 3'd4;
    localparam logic [2:0] CFG_CM_VERT    = 3'd5;
    localparam logic [2:0] CFG_CM_HORIZ   = 3'd6;

    // Configuration register file.
    typedef struct packed {
        logic [5:0] start_row;
        logic [5:0] start_col;
        logic [5:0] target_row;
        logic [5:0] target_col;
        logic [1:0] initial_heading;
        logic [7:0] cm_vert;
        logic [7:0] cm_horiz;
    } cfg_t;

    // Run state carried from one point to the next.
    typedef struct packed {
        logic [5:0] cur_row;
        logic [5:0] cur_col;
        logic [1:0] heading;
        logic [7:0] straight_steps;
        logic       finished;
    } run_t;

    // One command produced by a point.
    typedef struct packed {
        logic        emit;
        logic [15:0] travel_cm;
        logic [1:0]  turn_code;
        logic        is_final;
    } cmd_t;

endpackage

>>> design/ptc_step.sv
// Combinational step logic: next run state and command for one path point.
`timescale 1ns / 1ps

module ptc_step
(
    input  ptc_pkg::cfg_t cfg,
    input  ptc_pkg::run_t run,
    input  logic          limit_reached,
    input  logic [5:0]    point_row,
    input  logic [5:0]    point_col,
    output ptc_pkg::run_t run_next,
    output ptc_pkg::cmd_t cmd,
    output logic          counted
);
    import ptc_pkg::*;

    logic       same_r;
    logic       same_c;
    logic       r_up;
    logic       r_down;
    logic       c_up;
    logic       c_down;
    logic       ahead;
    logic       right;
    logic       left;
    logic [1:0] right_head;
    logic [1:0] left_head;
    logic       hit_target;
    logic [7:0] step_count;
    logic [7:0] cm;
    logic [15:0] distance;

    // Position of the point relative to the current cell.
    assign same_r = (point_row == run.cur_row);
    assign same_c = (point_col == run.cur_col);
    assign r_up   = (point_row > run.cur_row);
    assign r_down = (point_row < run.cur_row);
    assign c_up   = (point_col > run.cur_col);
    assign c_down = (point_col < run.cur_col);
    assign hit_target = (point_row == cfg.target_row) && (point_col == cfg.target_col);

    // Classify the point against the heading.
    always_comb
    begin
        case (run.heading)
            HEAD_N:
            begin
                ahead      = r_down && same_c;
                right      = same_r && c_up;
                left       = same_r && c_down;
                right_head = HEAD_E;
                left_head  = HEAD_W;
            end
            HEAD_E:
            begin
                ahead      = same_r && c_up;
                right      = r_up && same_c;
                left       = r_down && same_c;
                right_head = HEAD_S;
                left_head  = HEAD_N;
            end
            HEAD_S:
            begin
                ahead      = r_up && same_c;
                right      = same_r && c_down;
                left       = same_r && c_up;
                right_head = HEAD_W;
                left_head  = HEAD_E;
            end
            default:
            begin
                ahead      = same_r && c_down;
                right      = r_down && same_c;
                left       = r_up && same_c;
                right_head = HEAD_N;
                left_head  = HEAD_S;
            end
        endcase
    end

    // Distance driven so far: steps plus one, saturated, times cm per block of the axis.
    assign step_count = (run.straight_steps == 8'hFF) ? 8'hFF : run.straight_steps + 8'd1;
    assign cm = (run.heading == HEAD_N || run.heading == HEAD_S) ? cfg.cm_vert : cfg.cm_horiz;
    assign distance = {8'd0, step_count} * {8'd0, cm};

    // Apply the rules in priority order: target, straight, turn.
    always_comb
    begin
        run_next      = run;
        cmd.emit      = 1'b0;
        cmd.travel_cm = distance;
        cmd.turn_code = CODE_END;
        cmd.is_final  = 1'b0;
        counted       = 1'b0;
        if (!run.finished && !limit_reached)
        begin
            counted = 1'b1;
            if (hit_target)
            begin
                cmd.emit          = 1'b1;
                cmd.turn_code     = CODE_END;
                cmd.is_final      = 1'b1;
                run_next.finished = 1'b1;
            end
            else if (ahead)
            begin
                if (run.straight_steps != 8'hFF)
                begin
                    run_next.straight_steps = run.straight_steps + 8'd1;
                end
                run_next.cur_row = point_row;
                run_next.cur_col = point_col;
            end
            else if (right || left)
            begin
                cmd.emit                = 1'b1;
                cmd.turn_code           = right ? CODE_RIGHT : CODE_LEFT;
                run_next.cur_row        = point_row;
                run_next.cur_col        = point_col;
                run_next.straight_steps = 8'd0;
                run_next.heading        = right ? right_head : left_head;
            end
        end
    end

endmodule

>>> design/path_to_turn_commands.sv
// Top level of the path to turn command block.
// Takes one grid path point per beat and produces turn and end commands. A point
// is held in an input register, then the step logic updates the run state and
// loads the result register, so one point is taken every cycle while the result
// register is free. A command that waits on m_axis_tready holds the point behind
// it in the input register, and the input stalls only while both registers are
// full and that command is not taken. The run state update (compare, one 8 by 8
// multiply, register load) is combinational into the run register, which sets the
// rate of one point per cycle when no command stalls. Any write to a listed
// configuration register restarts the run from the start cell and initial heading.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module path_to_turn_commands
#(
    parameter int MAX_POINTS = ptc_pkg::MAX_POINTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] point_row, [11:6] point_col, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] travel_cm
    output logic [1:0]  m_axis_tuser,   // [1:0] turn_code
    output logic        m_axis_tlast    // is_final
);
    import ptc_pkg::*;

    localparam int PW = $clog2(MAX_POINTS + 1);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          cfg_hit;
    run_t          run_reg;
    run_t          run_step;
    run_t          run_restart;
    logic [PW-1:0] points_reg;
    logic          limit_reached;
    logic          counted;
    cmd_t          cmd;
    logic          in_valid_reg;
    logic [5:0]    in_row_reg;
    logic [5:0]    in_col_reg;
    logic          out_valid_reg;
    logic [15:0]   out_travel_reg;
    logic [1:0]    out_code_reg;
    logic          out_final_reg;
    logic          out_free;
    logic          advance;

    // Configuration register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = cfg_we;
        case (cfg_index)
            CFG_START_ROW:  cfg_next.start_row       = cfg_data[5:0];
            CFG_START_COL:  cfg_next.start_col       = cfg_data[5:0];
            CFG_TARGET_ROW: cfg_next.target_row      = cfg_data[5:0];
            CFG_TARGET_COL: cfg_next.target_col      = cfg_data[5:0];
            CFG_HEADING:    cfg_next.initial_heading = cfg_data[1:0];
            CFG_CM_VERT:    cfg_next.cm_vert         = cfg_data;
            CFG_CM_HORIZ:   cfg_next.cm_horiz        = cfg_data;
            default:        cfg_hit                  = 1'b0;
        endcase
    end

    // Run state reloaded on a restart.
    always_comb
    begin
        run_restart.cur_row        = cfg_next.start_row;
        run_restart.cur_col        = cfg_next.start_col;
        run_restart.heading        = cfg_next.initial_heading;
        run_restart.straight_steps = 8'd0;
        run_restart.finished       = 1'b0;
    end

    // Handshake: the result register frees when empty or being taken.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign limit_reached = (points_reg == PW'(MAX_POINTS));

    ptc_step u_step
    (
        .cfg           (cfg_reg),
        .run           (run_reg),
        .limit_reached (limit_reached),
        .point_row     (in_row_reg),
        .point_col     (in_col_reg),
        .run_next      (run_step),
        .cmd           (cmd),
        .counted       (counted)
    );

    // Configuration and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= '0;
            run_reg    <= '0;
            points_reg <= '0;
        end
        else if (cfg_hit)
        begin
            cfg_reg    <= cfg_next;
            run_reg    <= run_restart;
            points_reg <= '0;
        end
        else if (advance)
        begin
            run_reg <= run_step;
            if (counted)
            begin
                points_reg <= points_reg + PW'(1);
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_row_reg <= s_axis_tdata[5:0];
            in_col_reg <= s_axis_tdata[11:6];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_travel_reg <= cmd.travel_cm;
            out_code_reg   <= cmd.turn_code;
            out_final_reg  <= cmd.is_final;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_travel_reg;
    assign m_axis_tuser  = out_code_reg;
    assign m_axis_tlast  = out_final_reg;

    // Checks on the block's own logic.
    `ASSERT_IMPL(a_final_is_end, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == CODE_END)
    `ASSERT_NEXT(a_finished_holds, clk, rst_n, run_reg.finished && !cfg_we, run_reg.finished)
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, !s_axis_tready, in_valid_reg && !out_free)
    `ASSERT_IMPL(a_points_bound, clk, rst_n, 1'b1, points_reg <= PW'(MAX_POINTS))

endmodule

>>> test/path_to_turn_commands_test.sv
// Self-checking testbench for the path to turn command block.
`timescale 1ns / 1ps

module path_to_turn_commands_test;
    import ptc_pkg::*;

    localparam int          MAX_PTS      = MAX_POINTS_DEFAULT;
    localparam int          ITEM_TARGET  = 400;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          WATCHDOG     = 2000;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;

    // Predicts the command stream and holds the commands still owed by the block.
    class turn_cmd_scoreboard;
        typedef struct packed {
            logic [15:0] travel_cm;
            logic [1:0]  turn_code;
            logic        is_final;
        } command_t;

        cfg_t     cfg;
        run_t     run;
        int       points_seen;
        command_t expected_cmds[$];
        int       mismatches;

        function new();
            cfg = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            run.cur_row        = cfg.start_row;
            run.cur_col        = cfg.start_col;
            run.heading        = cfg.initial_heading;
            run.straight_steps = '0;
            run.finished       = 1'b0;
            points_seen        = 0;
        endfunction

        // Any write to a listed register restarts the run; other indexes do nothing.
        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                CFG_START_ROW:  cfg.start_row       = data[5:0];
                CFG_START_COL:  cfg.start_col       = data[5:0];
                CFG_TARGET_ROW: cfg.target_row      = data[5:0];
                CFG_TARGET_COL: cfg.target_col      = data[5:0];
                CFG_HEADING:    cfg.initial_heading = data[1:0];
                CFG_CM_VERT:    cfg.cm_vert         = data;
                CFG_CM_HORIZ:   cfg.cm_horiz        = data;
                default:        return;
            endcase
            restart();
        endfunction

        // True when the point lies strictly beyond the current cell in direction dir.
        function bit lies_toward(logic [1:0] dir, logic [5:0] r, logic [5:0] c);
            case (dir)
                HEAD_N:  return (c == run.cur_col) && (r < run.cur_row);
                HEAD_E:  return (r == run.cur_row) && (c > run.cur_col);
                HEAD_S:  return (c == run.cur_col) && (r > run.cur_row);
                default: return (r == run.cur_row) && (c < run.cur_col);
            endcase
        endfunction

        // Steps plus one, saturated, times the scale of the axis currently driven.
        function logic [15:0] leg_distance();
            logic [8:0] blocks;
            logic [7:0] scale;
            blocks = {1'b0, run.straight_steps} + 9'd1;
            if (blocks > 9'd255)
                blocks = 9'd255;
            scale = (run.heading == HEAD_N || run.heading == HEAD_S) ? cfg.cm_vert
                                                                      : cfg.cm_horiz;
            return {8'd0, blocks[7:0]} * {8'd0, scale};
        endfunction

        // Advances the run by one accepted point; returns 1 if the point was live.
        function bit note_point(logic [5:0] r, logic [5:0] c);
            command_t   cmd;
            logic [1:0] right_dir;
            logic [1:0] left_dir;
            if (run.finished || points_seen >= MAX_PTS)
                return 1'b0;
            points_seen++;

            // The target wins over every other rule.
            if (r == cfg.target_row && c == cfg.target_col)
            begin
                cmd.travel_cm = leg_distance();
                cmd.turn_code = CODE_END;
                cmd.is_final  = 1'b1;
                expected_cmds.push_back(cmd);
                run.finished = 1'b1;
                return 1'b1;
            end

            right_dir = run.heading + 2'd1;
            left_dir  = run.heading - 2'd1;
            if (lies_toward(run.heading, r, c))
            begin
                if (run.straight_steps != 8'd255)
                    run.straight_steps++;
                run.cur_row = r;
                run.cur_col = c;
            end
            else if (lies_toward(right_dir, r, c) || lies_toward(left_dir, r, c))
            begin
                cmd.travel_cm = leg_distance();
                cmd.turn_code = lies_toward(right_dir, r, c) ? CODE_RIGHT : CODE_LEFT;
                cmd.is_final  = 1'b0;
                expected_cmds.push_back(cmd);
                run.heading        = lies_toward(right_dir, r, c) ? right_dir : left_dir;
                run.cur_row        = r;
                run.cur_col        = c;
                run.straight_steps = '0;
            end
            return 1'b1;
        endfunction

        // Compares one command beat with the oldest one owed.
        function void check_command(logic [15:0] travel, logic [1:0] code, logic last);
            command_t want;
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command: travel %0d code %0d final %0d",
                             travel, code, last);
                return;
            end
            want = expected_cmds.pop_front();
            if (want.travel_cm !== travel || want.turn_code !== code
                    || want.is_final !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.travel_cm, want.turn_code, want.is_final,
                             travel, code, last);
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [7:0]  cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    turn_cmd_scoreboard sb = new();
    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    int sent_points     = 0;
    int quiet_cycles    = 0;

    path_to_turn_commands dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver side: random backpressure at the rate of the current phase.
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= ready_stall_pct);
    end

    // Check every command beat taken from the block.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_command(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Watchdog: ends the run after too many cycles with no beat on either side.
    initial
    begin
        wait (rst_n);
        while (quiet_cycles < WATCHDOG)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Writes one register at the next edge; the caller lowers cfg_we after the batch.
    task automatic cfg_write(logic [2:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Waits until every owed command has come and the pipeline has emptied.
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offers one point, with random gaps before it, and waits for the beat.
    task automatic send_point(logic [5:0] r, logic [5:0] c);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, c, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        void'(sb.note_point(r, c));
        sent_points++;
    endtask

    // Picks a cell strictly beyond the current one in direction dir, if there is one.
    task automatic cell_toward(input logic [1:0] dir, output bit ok,
                               output logic [5:0] r, output logic [5:0] c);
        int row;
        int col;
        row = int'(sb.run.cur_row);
        col = int'(sb.run.cur_col);
        ok  = 1'b1;
        case (dir)
            HEAD_N:  if (row == 0) ok = 1'b0; else row = $urandom_range(0, row - 1);
            HEAD_E:  if (col == 63) ok = 1'b0; else col = $urandom_range(col + 1, 63);
            HEAD_S:  if (row == 63) ok = 1'b0; else row = $urandom_range(row + 1, 63);
            default: if (col == 0) ok = 1'b0; else col = $urandom_range(0, col - 1);
        endcase
        r = row[5:0];
        c = col[5:0];
    endtask

    // Mostly well-formed moves from the current cell, some target hits and noise.
    task automatic next_path_point(output logic [5:0] r, output logic [5:0] c);
        int         pick;
        bit         ok;
        logic [1:0] dir;
        pick = $urandom_range(0, 99);
        ok   = 1'b0;
        if (pick < 5)
        begin
            r  = sb.cfg.target_row;
            c  = sb.cfg.target_col;
            ok = 1'b1;
        end
        else if (pick < 88)
        begin
            if (pick < 45)
                dir = sb.run.heading;
            else if (pick < 67)
                dir = sb.run.heading + 2'd1;
            else
                dir = sb.run.heading - 2'd1;
            cell_toward(dir, ok, r, c);
        end
        if (!ok)
        begin
            r = 6'($urandom_range(0, 63));
            c = 6'($urandom_range(0, 63));
        end
    endtask

    // Configuration for one random phase; every fifth phase uses extreme values.
    task automatic configure_phase(int phase);
        logic [7:0] scale;
        bit         wrote;
        if (phase % 5 == 0)
        begin
            scale = (phase % 10 == 0) ? 8'd255 : 8'd0;
            cfg_write(CFG_START_ROW, $urandom_range(0, 1) ? 8'hff : 8'h00);
            cfg_write(CFG_START_COL, $urandom_range(0, 1) ? 8'h3f : 8'hc0);
            cfg_write(CFG_TARGET_ROW, $urandom_range(0, 1) ? 8'h3f : 8'h00);
            cfg_write(CFG_TARGET_COL, $urandom_range(0, 1) ? 8'h3f : 8'h00);
            cfg_write(CFG_HEADING, 8'($urandom_range(0, 255)));
            cfg_write(CFG_CM_VERT, scale);
            cfg_write(CFG_CM_HORIZ, scale);
        end
        else
        begin
            wrote = 1'b0;
            for (int idx = 0; idx <= int'(CFG_CM_HORIZ); idx++)
            begin
                if ($urandom_range(0, 99) < 60)
                begin
                    cfg_write(idx[2:0], 8'($urandom_range(0, 255)));
                    wrote = 1'b1;
                end
            end
            if (!wrote)
                cfg_write(CFG_HEADING, 8'($urandom_range(0, 255)));
        end
        // The unused index must leave the run alone.
        if (phase % 7 == 3)
            cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        logic [5:0] dir_rows[$];
        logic [5:0] dir_cols[$];
        logic [5:0] r;
        logic [5:0] c;
        int         phase;
        int         count;

        // Turns through every heading both ways and steps straight to the grid edges,
        // with a point behind, one on the same cell and one off both axes along the way,
        // then the target and a point after the end.
        dir_rows = '{20, 0,  0, 10, 63, 63, 63, 63, 10, 63,  0,  0, 20, 20,  0, 63, 5};
        dir_cols = '{32, 32, 0,  0,  0, 40, 20, 40, 10, 50, 50, 60, 60, 30, 30, 63, 5};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the start cell is also the target and every scale is zero.
        send_point(6'd0, 6'd0);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        cfg_write(CFG_START_ROW, 8'd32);
        cfg_write(CFG_START_COL, 8'd32);
        cfg_write(CFG_TARGET_ROW, 8'd63);
        cfg_write(CFG_TARGET_COL, 8'd63);
        cfg_write(CFG_HEADING, {6'b0, HEAD_N});
        cfg_write(CFG_CM_VERT, 8'd255);
        cfg_write(CFG_CM_HORIZ, 8'd1);
        cfg_we <= 1'b0;
        foreach (dir_rows[i])
            send_point(dir_rows[i], dir_cols[i]);
        s_axis_tvalid <= 1'b0;

        // Random phases, rotating through the idling patterns.
        phase = 0;
        while (sent_points < ITEM_TARGET)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    ready_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 59;
                    ready_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    ready_stall_pct = 59;
                end
                default:
                begin
                    sender_idle_pct = 23;
                    ready_stall_pct = 23;
                end
            endcase
            wait_idle();
            configure_phase(phase);
            count = $urandom_range(18, 26);
            for (int k = 0; k < count; k++)
            begin
                // Now and then hold the sender until all owed commands are out.
                if (phase % 3 == 1 && k == 10)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                next_path_point(r, c);
                send_point(r, c);
            end
            s_axis_tvalid <= 1'b0;
            phase++;
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
